>>> hw/rtl/cca_pkg.sv
`default_nettype none

package cca_pkg;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_DAY  = 2'd1;
	localparam logic [1:0] OP_LOAD = 2'd2;

	localparam logic [16:0] SECS_PER_DAY = 17'd86400;

	// reset values, 1 jan 1970, a thursday
	localparam logic [5:0]  RST_SECOND  = 6'd0;
	localparam logic [5:0]  RST_MINUTE  = 6'd0;
	localparam logic [4:0]  RST_HOUR    = 5'd0;
	localparam logic [2:0]  RST_WEEKDAY = 3'd5;
	localparam logic [4:0]  RST_MDAY    = 5'd1;
	localparam logic [8:0]  RST_YDAY    = 9'd1;
	localparam logic [3:0]  RST_MONTH   = 4'd1;
	localparam logic [15:0] RST_YEAR    = 16'd1970;

	localparam logic [6:0]  LIM_SECOND  = 7'd60;
	localparam logic [6:0]  LIM_MINUTE  = 7'd60;
	localparam logic [5:0]  LIM_HOUR    = 6'd24;
	localparam logic [3:0]  LIM_WEEKDAY = 4'd8;
	localparam logic [4:0]  LIM_MONTH   = 5'd13;
	localparam logic [9:0]  LIM_YDAY_LEAP = 10'd367;
	localparam logic [9:0]  LIM_YDAY_NORM = 10'd366;
	localparam logic [16:0] LIM_YEAR    = 17'h10000;

	// multiplicative inverse of 25 mod 2^16, and the largest multiple quotient
	localparam logic [15:0] INV25    = 16'd23593;
	localparam logic [15:0] MAX_Q25  = 16'd2621;

	localparam logic [4:0] MONTH_LEN [13] = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31,
		5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

	typedef struct packed {
		logic [1:0]         op;
		logic [5:0]         load_second;
		logic [5:0]         load_minute;
		logic [4:0]         load_hour;
		logic [2:0]         load_weekday;
		logic [4:0]         load_mday;
		logic [8:0]         load_yday;
		logic [3:0]         load_month;
		logic [15:0]        load_year;
		logic signed [63:0] load_epoch;
	} cca_cmd_t;

	typedef struct packed {
		logic [5:0]         sec_out;
		logic [5:0]         min_out;
		logic [4:0]         hour_out;
		logic [2:0]         weekday_out;
		logic [4:0]         mday_out;
		logic [8:0]         yday_out;
		logic [3:0]         month_out;
		logic [15:0]        year_out;
		logic signed [63:0] epoch_out;
	} cca_time_t;

	// gregorian rule; divisibility by 25 via inverse multiply
	function automatic logic is_leap(input logic [15:0] y);
		logic [31:0] prod;
		logic        div25;
		prod  = 32'(y) * 32'(INV25);
		div25 = (prod[15:0] <= MAX_Q25);
		return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		if (m == 4'd0 || m > 4'd12) begin
			d = 5'd31;
		end else if (m == 4'd2 && leap) begin
			d = 5'd29;
		end else begin
			d = MONTH_LEN[m];
		end
		return d;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cca_ifs.sv
`default_nettype none

interface cca_cmd_if;
	logic               valid;
	logic               ready;
	cca_pkg::cca_cmd_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cca_time_if;
	logic               valid;
	logic               ready;
	cca_pkg::cca_time_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cca_cell.sv
`default_nettype none

module cca_cell #(
	parameter int W = 6,
	parameter logic [W-1:0] START = '0,
	parameter logic [W-1:0] RST = '0
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         ld,
	input  wire logic [W-1:0] ld_val,
	input  wire logic         inc,
	input  wire logic [W:0]   limit,
	output logic [W-1:0]      val,
	output logic              carry
);

	logic [W-1:0] val_q;
	logic [W:0]   raised;

	assign raised = {1'b0, val_q} + {{W{1'b0}}, 1'b1};
	assign carry  = inc && (raised >= limit);
	assign val    = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= RST;
		end else if (en) begin
			if (ld) begin
				val_q <= ld_val;
			end else if (carry) begin
				val_q <= START;
			end else if (inc) begin
				val_q <= raised[W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/cca_epoch.sv
`default_nettype none

module cca_epoch (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               ld,
	input  wire logic signed [63:0] ld_val,
	input  wire logic               tick,
	input  wire logic               day,
	output logic signed [63:0]      epoch
);
	import cca_pkg::*;

	logic signed [63:0] epoch_q;
	logic [16:0]        step;

	always_comb begin
		step = '0;
		if (tick) begin
			step = 17'd1;
		end else if (day) begin
			step = SECS_PER_DAY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= '0;
		end else if (en) begin
			if (ld) begin
				epoch_q <= ld_val;
			end else begin
				epoch_q <= epoch_q + signed'({47'd0, step});
			end
		end
	end

	assign epoch = epoch_q;

endmodule

`default_nettype wire

>>> hw/rtl/calendar_clock_advance.sv
// the result word for an accepted command is offered in the cycle after it is accepted
// throughput: one command per cycle; the carry runs through the whole row of
//   counter cells (second to year) and the 64-bit epoch adder in that cycle
// a waiting result word holds off the next command until it is taken
// reset (arst_n low): 00:00:00 thursday 1 jan 1970, day of year 1, epoch 0
`default_nettype none

module calendar_clock_advance (
	input wire logic   clk,
	input wire logic   arst_n,
	cca_cmd_if.sink    cmd,
	cca_time_if.source tim
);
	import cca_pkg::*;

	logic accept;
	logic vld_q;
	logic ld, tick, day;
	logic leap;
	logic day_inc;
	logic c_sec, c_min, c_hour, c_wday, c_mday, c_month, c_yday, c_year;
	logic [5:0] mday_lim;
	logic [9:0] yday_lim;

	assign cmd.ready = !vld_q || tim.ready;
	assign accept    = cmd.valid && cmd.ready;

	assign ld   = (cmd.data.op == OP_LOAD);
	assign tick = (cmd.data.op == OP_TICK);
	assign day  = (cmd.data.op == OP_DAY);

	assign leap     = is_leap(tim.data.year_out);
	assign mday_lim = {1'b0, month_days(tim.data.month_out, leap)} + 6'd1;
	assign yday_lim = leap ? LIM_YDAY_LEAP : LIM_YDAY_NORM;
	assign day_inc  = day || c_hour;

	cca_cell #(.W(6), .START(6'd0), .RST(RST_SECOND)) u_sec (
		.clk, .arst_n, .en(accept), .ld, .ld_val(cmd.data.load_second),
		.inc(tick), .limit(LIM_SECOND), .val(tim.data.sec_out), .carry(c_sec)
	);

	cca_cell #(.W(6), .START(6'd0), .RST(RST_MINUTE)) u_min (
		.clk, .arst_n, .en(accept), .ld, .ld_val(cmd.data.load_minute),
		.inc(c_sec), .limit(LIM_MINUTE), .val(tim.data.min_out), .carry(c_min)
	);

	cca_cell #(.W(5), .START(5'd0), .RST(RST_HOUR)) u_hour (
		.clk, .arst_n, .en(accept), .ld, .ld_val(cmd.data.load_hour),
		.inc(c_min), .limit(LIM_HOUR), .val(tim.data.hour_out), .carry(c_hour)
	);

	// weekday carry goes nowhere, the week has no neighbour
	cca_cell #(.W(3), .START(3'd1), .RST(RST_WEEKDAY)) u_wday (
		.clk, .arst_n, .en(accept), .ld, .ld_val(cmd.data.load_weekday),
		.inc(day_inc), .limit(LIM_WEEKDAY), .val(tim.data.weekday_out), .carry(c_wday)
	);

	cca_cell #(.W(5), .START(5'd1), .RST(RST_MDAY)) u_mday (
		.clk, .arst_n, .en(accept), .ld, .ld_val(cmd.data.load_mday),
		.inc(day_inc), .limit(mday_lim), .val(tim.data.mday_out), .carry(c_mday)
	);

	cca_cell #(.W(4), .START(4'd1), .RST(RST_MONTH)) u_month (
		.clk, .arst_n, .en(accept), .ld, .ld_val(cmd.data.load_month),
		.inc(c_mday), .limit(LIM_MONTH), .val(tim.data.month_out), .carry(c_month)
	);

	cca_cell #(.W(9), .START(9'd1), .RST(RST_YDAY)) u_yday (
		.clk, .arst_n, .en(accept), .ld, .ld_val(cmd.data.load_yday),
		.inc(day_inc), .limit(yday_lim), .val(tim.data.yday_out), .carry(c_yday)
	);

	// year wraps to zero past 65535
	cca_cell #(.W(16), .START(16'd0), .RST(RST_YEAR)) u_year (
		.clk, .arst_n, .en(accept), .ld, .ld_val(cmd.data.load_year),
		.inc(c_yday), .limit(LIM_YEAR), .val(tim.data.year_out), .carry(c_year)
	);

	cca_epoch u_epoch (
		.clk, .arst_n, .en(accept), .ld, .ld_val(cmd.data.load_epoch),
		.tick, .day, .epoch(tim.data.epoch_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (accept) begin
			vld_q <= 1'b1;
		end else if (tim.ready) begin
			vld_q <= 1'b0;
		end
	end

	assign tim.valid = vld_q;

	// terminal carries of the week and the year row are not used further
	logic unused_carries;
	assign unused_carries = c_wday ^ c_month ^ c_year;

endmodule

`default_nettype wire

>>> hw/rtl/cca_chk.sv
`default_nettype none

module cca_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               cmd_valid,
	input wire logic               cmd_ready,
	input wire cca_pkg::cca_cmd_t  cmd_data,
	input wire logic               tim_valid,
	input wire logic               tim_ready,
	input wire cca_pkg::cca_time_t tim_data
);
	import cca_pkg::*;

	logic acc;
	assign acc = cmd_valid && cmd_ready;

	// an accepted word always produces a result word next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> tim_valid)
		else $error("no result word after accepted command");

	// a plain tick below the minute boundary moves seconds and epoch by one and leaves minutes alone
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd_data.op == OP_TICK && tim_data.sec_out < 6'd59 |=>
		tim_data.sec_out == $past(tim_data.sec_out) + 6'd1 &&
		tim_data.min_out == $past(tim_data.min_out) &&
		tim_data.epoch_out == $past(tim_data.epoch_out) + 64'sd1)
		else $error("second tick wrong");

	// a day advance leaves seconds and hours alone and adds a day of seconds
	a_day: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd_data.op == OP_DAY |=>
		tim_data.sec_out == $past(tim_data.sec_out) &&
		tim_data.hour_out == $past(tim_data.hour_out) &&
		tim_data.epoch_out == $past(tim_data.epoch_out) + 64'sd86400)
		else $error("day advance wrong");

	// load takes second, day of year, year and epoch as given
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd_data.op == OP_LOAD |=>
		tim_data.sec_out == $past(cmd_data.load_second) &&
		tim_data.yday_out == $past(cmd_data.load_yday) &&
		tim_data.year_out == $past(cmd_data.load_year) &&
		tim_data.epoch_out == $past(cmd_data.load_epoch))
		else $error("load wrong");

	// with no accepted word the reported time holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(tim_data))
		else $error("time moved without a command");

endmodule

bind calendar_clock_advance cca_chk u_cca_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.cmd_data  (cmd.data),
	.tim_valid (tim.valid),
	.tim_ready (tim.ready),
	.tim_data  (tim.data)
);

`default_nettype wire
